// ===== rtl/transformed_vertex_bounding_box_unit_defines.svh =====
// Assertion macros for the transformed-vertex bounding box unit.
// Used by the RTL files that carry concurrent assertions; needs i_clk and i_rst_n in scope.
`ifndef TRANSFORMED_VERTEX_BOUNDING_BOX_UNIT_DEFINES_SVH
`define TRANSFORMED_VERTEX_BOUNDING_BOX_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TVBB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TVBB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tvbb_pkg.sv =====
// Shared types and constants of the transformed-vertex bounding box unit.
// No dependencies; every other RTL file but the assertion macro header imports it.
package tvbb_pkg;

    localparam int COORD_BITS     = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int COEF_BITS      = 16;
    localparam int BOX_BITS       = 19;
    localparam int HALF_BITS      = 18;
    localparam int CFG_W          = 48;
    localparam int CFG_IDX_W      = 3;
    localparam int AXES           = 3;

    localparam int PROD_W = COORD_BITS + COEF_BITS;
    localparam int SUM_W  = PROD_W + 2;
    localparam int ACC_W  = (SUM_W > COEF_FRAC_BITS + BOX_BITS) ? SUM_W
                                                                 : COEF_FRAC_BITS + BOX_BITS;

    typedef logic signed [BOX_BITS-1:0]   t_box;
    typedef logic signed [ACC_W-1:0]      t_acc;
    typedef logic        [COORD_BITS-1:0] t_coord;

    localparam t_box BOX_MAX    = t_box'((2 ** (BOX_BITS - 1)) - 1);
    localparam t_box BOX_MIN    = t_box'(-(2 ** (BOX_BITS - 1)));
    localparam t_acc ROUND_HALF = t_acc'(1) <<< (COEF_FRAC_BITS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_X = 3'd0,
        CFG_ROW_Y = 3'd1,
        CFG_ROW_Z = 3'd2,
        CFG_TRANS = 3'd3,
        CFG_SKIP  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [AXES-1:0][CFG_W-1:0] rows;
        logic [CFG_W-1:0]           trans;
        logic                       skip;
    } t_cfg;

    // Transformed vertex handed from the transform stage to the box stage.
    typedef struct packed {
        logic                vld;
        logic                last;
        logic [AXES-1:0][BOX_BITS-1:0] val;
    } t_xf_word;

endpackage

// ===== rtl/tvbb_vert_if.sv =====
// Vertex input channel of the transformed-vertex bounding box unit.
// Depends on tvbb_pkg.
interface tvbb_vert_if import tvbb_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  vert_x;
    logic signed [COORD_BITS-1:0]  vert_y;
    logic signed [COORD_BITS-1:0]  vert_z;
    logic                          last_vertex;

    modport source (output valid, vert_x, vert_y, vert_z, last_vertex, input ready);
    modport sink   (input valid, vert_x, vert_y, vert_z, last_vertex, output ready);
endinterface

// ===== rtl/tvbb_box_if.sv =====
// Box result channel of the transformed-vertex bounding box unit.
// Depends on tvbb_pkg.
interface tvbb_box_if import tvbb_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [BOX_BITS-1:0]  min_x;
    logic signed [BOX_BITS-1:0]  min_y;
    logic signed [BOX_BITS-1:0]  min_z;
    logic signed [BOX_BITS-1:0]  max_x;
    logic signed [BOX_BITS-1:0]  max_y;
    logic signed [BOX_BITS-1:0]  max_z;
    logic signed [BOX_BITS-1:0]  centre_x;
    logic signed [BOX_BITS-1:0]  centre_y;
    logic signed [BOX_BITS-1:0]  centre_z;
    logic        [HALF_BITS-1:0] half_extent_x;
    logic        [HALF_BITS-1:0] half_extent_y;
    logic        [HALF_BITS-1:0] half_extent_z;

    modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z,
                    centre_x, centre_y, centre_z,
                    half_extent_x, half_extent_y, half_extent_z,
                    input ready);
    modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z,
                    centre_x, centre_y, centre_z,
                    half_extent_x, half_extent_y, half_extent_z,
                    output ready);
endinterface

// ===== rtl/tvbb_xform.sv =====
// Vertex input register and matrix/translation stage.
// Depends on tvbb_pkg and tvbb_vert_if.
module tvbb_xform import tvbb_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    input  logic            i_take,
    tvbb_vert_if.sink       i_vert,
    output t_xf_word        o_xf
);

    logic                         r_s1_vld;
    logic                         r_s1_last;
    logic [AXES-1:0][COORD_BITS-1:0] r_s1_vert;
    logic                         r_s2_vld;
    logic                         r_s2_last;
    logic [AXES-1:0][BOX_BITS-1:0] r_s2_val;

    logic w_s2_ready;
    logic w_s1_move;
    logic w_in_acc;

    logic signed [PROD_W-1:0]    w_prod [AXES][AXES];
    t_acc                        w_ext  [AXES][AXES];
    t_acc                        w_sum  [AXES];
    logic signed [COEF_BITS-1:0] w_tslot [AXES];
    t_box                        w_tr   [AXES];
    logic [AXES-1:0][BOX_BITS-1:0] n_val;

    assign w_s2_ready   = !r_s2_vld || i_take;
    assign w_s1_move    = r_s1_vld && w_s2_ready;
    assign i_vert.ready = !r_s1_vld || w_s2_ready;
    assign w_in_acc     = i_vert.valid && i_vert.ready;
    assign o_xf.vld     = r_s2_vld;
    assign o_xf.last    = r_s2_last;
    assign o_xf.val     = r_s2_val;

    // Three products per axis, round to nearest, then translate unless skip is set; wrap to box width.
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            for (int c = 0; c < AXES; c++) begin
                w_prod[a][c] = $signed(r_s1_vert[c])
                             * $signed(i_cfg.rows[a][c*COEF_BITS +: COEF_BITS]);
                w_ext[a][c]  = t_acc'(w_prod[a][c]);
            end
            w_sum[a]   = w_ext[a][0] + w_ext[a][1] + w_ext[a][2] + ROUND_HALF;
            w_tslot[a] = $signed(i_cfg.trans[a*COEF_BITS +: COEF_BITS]);
            w_tr[a]    = i_cfg.skip ? '0 : t_box'(w_tslot[a]);
            n_val[a]   = w_sum[a][COEF_FRAC_BITS +: BOX_BITS] + w_tr[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (w_s1_move) begin
                r_s2_vld <= 1'b1;
            end else if (i_take) begin
                r_s2_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_last    <= i_vert.last_vertex;
            r_s1_vert[0] <= i_vert.vert_x;
            r_s1_vert[1] <= i_vert.vert_y;
            r_s1_vert[2] <= i_vert.vert_z;
        end
        if (w_s1_move) begin
            r_s2_last <= r_s1_last;
            r_s2_val  <= n_val;
        end
    end

endmodule

// ===== rtl/tvbb_box.sv =====
// Running min/max accumulators and the box result register.
// Depends on tvbb_pkg, tvbb_box_if and the assertion macro header.
`include "transformed_vertex_bounding_box_unit_defines.svh"

module tvbb_box import tvbb_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_xf_word        i_xf,
    output logic            o_take,
    tvbb_box_if.source      o_box
);

    t_box r_min [AXES];
    t_box r_max [AXES];
    logic r_out_vld;

    t_box n_min [AXES];
    t_box n_max [AXES];
    logic signed [BOX_BITS:0] w_add [AXES];
    logic signed [BOX_BITS:0] w_sub [AXES];
    logic w_out_free;
    logic w_emit;

    assign w_out_free  = !r_out_vld || o_box.ready;
    assign w_emit      = i_xf.vld && i_xf.last && w_out_free;
    assign o_take      = i_xf.vld && (!i_xf.last || w_out_free);
    assign o_box.valid = r_out_vld;

    // Fold the incoming value into the box, then form centre and half extent.
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_min[a] = ($signed(i_xf.val[a]) < r_min[a]) ? $signed(i_xf.val[a]) : r_min[a];
            n_max[a] = ($signed(i_xf.val[a]) > r_max[a]) ? $signed(i_xf.val[a]) : r_max[a];
            w_add[a] = n_max[a] + n_min[a];
            w_sub[a] = n_max[a] - n_min[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                r_min[a] <= BOX_MAX;
                r_max[a] <= BOX_MIN;
            end
        end else begin
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (o_box.ready) begin
                r_out_vld <= 1'b0;
            end
            if (o_take) begin
                for (int a = 0; a < AXES; a++) begin
                    r_min[a] <= i_xf.last ? BOX_MAX : n_min[a];
                    r_max[a] <= i_xf.last ? BOX_MIN : n_max[a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_box.min_x         <= n_min[0];
            o_box.min_y         <= n_min[1];
            o_box.min_z         <= n_min[2];
            o_box.max_x         <= n_max[0];
            o_box.max_y         <= n_max[1];
            o_box.max_z         <= n_max[2];
            o_box.centre_x      <= w_add[0][BOX_BITS:1];
            o_box.centre_y      <= w_add[1][BOX_BITS:1];
            o_box.centre_z      <= w_add[2][BOX_BITS:1];
            o_box.half_extent_x <= w_sub[0][HALF_BITS:1];
            o_box.half_extent_y <= w_sub[1][HALF_BITS:1];
            o_box.half_extent_z <= w_sub[2][HALF_BITS:1];
        end
    end

    `TVBB_ASSERT_NEXT(a_emit_sets_valid, w_emit, r_out_vld, "box result not raised after emit")
    `TVBB_ASSERT_NEXT(a_emit_clears_box, w_emit, (r_min[0] == BOX_MAX) && (r_max[0] == BOX_MIN), "box not cleared after emit")
    `TVBB_ASSERT_NOW(a_box_ordered, r_out_vld, ($signed(o_box.min_x) <= $signed(o_box.max_x)) && ($signed(o_box.min_z) <= $signed(o_box.max_z)), "box min above max")
    `TVBB_ASSERT_NOW(a_marked_held, i_xf.vld && i_xf.last && r_out_vld && !o_box.ready, !o_take, "marked vertex taken while result unread")

endmodule

// ===== rtl/transformed_vertex_bounding_box_unit.sv =====
// Top level of the transformed-vertex bounding box unit.
// Depends on tvbb_pkg, tvbb_vert_if, tvbb_box_if, tvbb_xform and tvbb_box.
//
// Usage:
//   i_vert carries one vertex word per handshake (valid && ready): signed x, y, z
//   and a last_vertex flag that closes the current set. o_box carries one box word
//   per closed set: per-axis min, max, centre and half extent.
//   The config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes the three matrix rows,
//   the packed translation and the skip-translation flag; write only while idle.
// Timing:
//   One vertex per cycle sustained while no marked vertex waits on the result
//   register. The marked vertex is registered in the input register on accept,
//   moves into the transform register, and its box is then registered in the
//   result register that drives o_box. The depth is set by the input register,
//   the multiply/round/translate register and the min/max result register.
// Stall:
//   Unmarked vertices keep flowing while a result waits on o_box. A marked vertex
//   holds in the transform stage until the result register frees, and the input
//   backs up behind it.
// Reset:
//   Identity matrix, zero translation, translation on, box cleared, pipeline empty.
module transformed_vertex_bounding_box_unit import tvbb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    tvbb_vert_if.sink            i_vert,
    tvbb_box_if.source           o_box
);

    t_cfg     r_cfg;
    t_xf_word w_xf;
    logic     w_take;

    // Decode register writes; unused indexes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows[0] <= CFG_W'(1) << COEF_FRAC_BITS;
            r_cfg.rows[1] <= CFG_W'(1) << (COEF_BITS + COEF_FRAC_BITS);
            r_cfg.rows[2] <= CFG_W'(1) << (2 * COEF_BITS + COEF_FRAC_BITS);
            r_cfg.trans   <= '0;
            r_cfg.skip    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROW_X: r_cfg.rows[0] <= i_cfg_data;
                CFG_ROW_Y: r_cfg.rows[1] <= i_cfg_data;
                CFG_ROW_Z: r_cfg.rows[2] <= i_cfg_data;
                CFG_TRANS: r_cfg.trans   <= i_cfg_data;
                CFG_SKIP:  r_cfg.skip    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input register and transform stage.
    tvbb_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_take  (w_take),
        .i_vert  (i_vert),
        .o_xf    (w_xf)
    );

    // Accumulators and result register.
    tvbb_box u_box (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_xf    (w_xf),
        .o_take  (w_take),
        .o_box   (o_box)
    );

endmodule
